// ===== sv/palette_gradient_generator_assert.svh =====
// Assertion macros used by the palette gradient generator checker.
`ifndef PALETTE_GRADIENT_GENERATOR_ASSERT_SVH
`define PALETTE_GRADIENT_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PGG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgg assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PGG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgg assertion failed");

`endif

// ===== sv/pgg_pkg.sv =====
// Package with the types, constants and helper functions of the palette gradient generator.
package pgg_pkg;

    localparam int ANGLE_W          = 16;
    localparam int CHAN_W           = 8;
    localparam int NUM_CHAN         = 3;
    localparam int COLOR_W          = CHAN_W * NUM_CHAN;
    localparam int NUM_COLORS       = 6;
    localparam int CNT_W            = $clog2(NUM_COLORS + 1);
    localparam int IDX_W            = $clog2(NUM_COLORS);
    localparam int PALETTE_SIZE_DEF = 6;
    localparam int FIFO_DEPTH_DEF   = 2;
    localparam int NUM_REGS         = 2 + NUM_COLORS;
    localparam int REG_IDX_W        = $clog2(NUM_REGS);
    localparam int APB_AW           = REG_IDX_W + 2;
    localparam int APB_DW           = 32;
    localparam int PROD_W           = (CHAN_W + 1) + (ANGLE_W + 1);

    localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SMOOTH_MODE = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_COLOR_0     = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_COLOR_5     = REG_IDX_W'(7);

    typedef logic [COLOR_W-1:0] color_t;

    localparam color_t WHITE = '1;
    localparam color_t COLOR_RESET [NUM_COLORS] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h000000, 24'h000000, 24'h000000
    };

    typedef struct packed {
        logic [NUM_COLORS-1:0] enable_mask;
        logic                  smooth_mode;
    } pgg_ctrl_t;

    typedef struct packed {
        color_t               color_a;
        color_t               color_b;
        logic [ANGLE_W-1:0]   frac;
        logic                 smooth;
    } pgg_item_t;

    function automatic logic [CNT_W-1:0] popcount(input logic [NUM_COLORS-1:0] m);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            n = n + CNT_W'(m[i]);
        end
        return n;
    endfunction

    // Position of the set bit whose rank among the set bits is n.
    function automatic logic [IDX_W-1:0] nth_set(input logic [NUM_COLORS-1:0] m,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] k;
        logic [IDX_W-1:0] r;
        k = '0;
        r = '0;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            if (m[i] && k == n)
            begin
                r = IDX_W'(i);
            end
            k = k + CNT_W'(m[i]);
        end
        return r;
    endfunction

endpackage

// ===== sv/pgg_if.sv =====
// Stream interfaces for the angle input and the color output.
interface pgg_angle_if;
    import pgg_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] phase_angle;
    logic [ANGLE_W-1:0] offset_angle;

    modport source (output valid, output phase_angle, output offset_angle, input ready);
    modport sink   (input valid, input phase_angle, input offset_angle, output ready);
endinterface

interface pgg_color_if;
    import pgg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/pgg_regs.sv =====
// APB configuration registers of the palette gradient generator.
module pgg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgg_pkg::APB_AW-1:0]  paddr,
    input  logic [pgg_pkg::APB_DW-1:0]  pwdata,
    output logic [pgg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output pgg_pkg::pgg_ctrl_t          ctrl,
    output pgg_pkg::color_t             colors [pgg_pkg::NUM_COLORS]
);
    import pgg_pkg::*;

    logic [NUM_COLORS-1:0] enable_mask_reg;
    logic                  smooth_mode_reg;
    color_t                color_reg [NUM_COLORS];
    logic [REG_IDX_W-1:0]  idx;
    logic [IDX_W-1:0]      color_idx;
    logic                  wr_en;

    assign pready    = 1'b1;
    assign idx       = paddr[APB_AW-1:2];
    assign color_idx = IDX_W'(idx - REG_COLOR_0);
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= '0;
            smooth_mode_reg <= 1'b1;
            for (int i = 0; i < NUM_COLORS; i++)
            begin
                color_reg[i] <= COLOR_RESET[i];
            end
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ENABLE_MASK: enable_mask_reg <= pwdata[NUM_COLORS-1:0];
                REG_SMOOTH_MODE: smooth_mode_reg <= pwdata[0];
                default:
                begin
                    if (idx inside {[REG_COLOR_0:REG_COLOR_5]})
                    begin
                        color_reg[color_idx] <= pwdata[COLOR_W-1:0];
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_ENABLE_MASK: prdata = APB_DW'(enable_mask_reg);
            REG_SMOOTH_MODE: prdata = APB_DW'(smooth_mode_reg);
            default:
            begin
                if (idx inside {[REG_COLOR_0:REG_COLOR_5]})
                begin
                    prdata = APB_DW'(color_reg[color_idx]);
                end
            end
        endcase
    end

    assign ctrl.enable_mask = enable_mask_reg;
    assign ctrl.smooth_mode = smooth_mode_reg;
    assign colors           = color_reg;

endmodule

// ===== sv/pgg_front.sv =====
// Front end: accepts angles, finds the segment and picks the two palette colors.
module pgg_front #(
    parameter int PALETTE_SIZE = pgg_pkg::PALETTE_SIZE_DEF
) (
    pgg_angle_if.sink            angle_ch,
    input  pgg_pkg::pgg_ctrl_t   ctrl,
    input  pgg_pkg::color_t      colors [pgg_pkg::NUM_COLORS],
    input  logic                 full,
    output logic                 push,
    output pgg_pkg::pgg_item_t   push_item
);
    import pgg_pkg::*;

    localparam logic [NUM_COLORS-1:0] USE_MASK = NUM_COLORS'((1 << PALETTE_SIZE) - 1);

    logic [NUM_COLORS-1:0]      mask;
    logic [CNT_W-1:0]           count;
    logic [ANGLE_W-1:0]         angle;
    logic [ANGLE_W+CNT_W-1:0]   prod;
    logic [CNT_W-1:0]           seg;
    logic [CNT_W-1:0]           seg_inc;
    logic [CNT_W-1:0]           nxt;
    logic [IDX_W-1:0]           idx_a;
    logic [IDX_W-1:0]           idx_b;

    assign mask    = ctrl.enable_mask & USE_MASK;
    assign count   = popcount(mask);
    assign angle   = angle_ch.phase_angle + angle_ch.offset_angle;
    assign prod    = {{CNT_W{1'b0}}, angle} * {{ANGLE_W{1'b0}}, count};
    assign seg     = prod[ANGLE_W+CNT_W-1:ANGLE_W];
    assign seg_inc = seg + CNT_W'(1);
    assign nxt     = (seg_inc == count) ? '0 : seg_inc;
    assign idx_a   = nth_set(mask, seg);
    assign idx_b   = nth_set(mask, nxt);

    assign angle_ch.ready = !full;
    assign push           = angle_ch.valid && !full;

    always_comb
    begin
        push_item.frac = prod[ANGLE_W-1:0];
        if (count == '0)
        begin
            push_item.color_a = WHITE;
            push_item.color_b = WHITE;
            push_item.smooth  = 1'b0;
        end
        else
        begin
            push_item.color_a = colors[idx_a];
            push_item.color_b = colors[idx_b];
            push_item.smooth  = ctrl.smooth_mode && (count != CNT_W'(1));
        end
    end

endmodule

// ===== sv/pgg_fifo.sv =====
// Short queue between the front end and the blend pipeline.
module pgg_fifo #(
    parameter int FIFO_DEPTH = pgg_pkg::FIFO_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pgg_pkg::pgg_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output pgg_pkg::pgg_item_t  pop_item
);
    import pgg_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W_Q = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

    pgg_item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W_Q-1:0]   cnt_reg;
    logic [CNT_W_Q-1:0]   cnt_next;

    assign full     = (cnt_reg == CNT_W_Q'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W_Q'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/pgg_back.sv =====
// Back end: per-channel blend multiply, then add and output register.
module pgg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  pgg_pkg::pgg_item_t  pop_item,
    output logic                pop,
    pgg_color_if.source         color_ch
);
    import pgg_pkg::*;

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg [NUM_CHAN];
    color_t                    s1_base_reg;
    logic                      s1_smooth_reg;
    logic                      out_valid_reg;
    color_t                    out_color_reg;
    logic                      out_en;
    logic                      s1_en;
    logic signed [PROD_W-1:0]  prod [NUM_CHAN];
    color_t                    mix;

    assign out_en = !out_valid_reg || color_ch.ready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign pop    = s1_en && !empty;

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod[c] = $signed({1'b0, pop_item.color_b[CHAN_W*c +: CHAN_W]}
                              - {1'b0, pop_item.color_a[CHAN_W*c +: CHAN_W]})
                      * $signed({1'b0, pop_item.frac});
        end
    end

    // floor division by 65536 is an arithmetic shift; result wraps to 8 bits
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            mix[CHAN_W*c +: CHAN_W] = s1_base_reg[CHAN_W*c +: CHAN_W]
                                      + s1_prod_reg[c][ANGLE_W +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= !empty;
            end
            if (out_en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_prod_reg   <= prod;
            s1_base_reg   <= pop_item.color_a;
            s1_smooth_reg <= pop_item.smooth;
        end
        if (out_en && s1_valid_reg)
        begin
            out_color_reg <= s1_smooth_reg ? mix : s1_base_reg;
        end
    end

    assign color_ch.valid = out_valid_reg;
    assign color_ch.red   = out_color_reg[2*CHAN_W +: CHAN_W];
    assign color_ch.green = out_color_reg[CHAN_W +: CHAN_W];
    assign color_ch.blue  = out_color_reg[0 +: CHAN_W];

endmodule

// ===== sv/palette_gradient_generator.sv =====
// Palette gradient generator: angle in, blended palette color out.
// An accepted angle passes the queue, the product stage and the output register in turn.
// Throughput: one item per cycle unless the output stalls; the front end is combinational.
// A 2-entry queue lets the input keep taking items while a result waits on the output.
// rst_n is asynchronous, active low; it empties the queue and pipeline and loads
// the register reset values (mask 0, smooth on, colors red, green, blue, black...).
module palette_gradient_generator #(
    parameter int PALETTE_SIZE = pgg_pkg::PALETTE_SIZE_DEF,
    parameter int FIFO_DEPTH   = pgg_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pgg_angle_if.sink                   angle_ch,
    pgg_color_if.source                 color_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgg_pkg::APB_AW-1:0]  paddr,
    input  logic [pgg_pkg::APB_DW-1:0]  pwdata,
    output logic [pgg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pgg_pkg::*;

    pgg_ctrl_t  ctrl;
    color_t     colors [NUM_COLORS];
    logic       full;
    logic       empty;
    logic       push;
    logic       pop;
    pgg_item_t  push_item;
    pgg_item_t  pop_item;

    pgg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctrl    (ctrl),
        .colors  (colors)
    );

    pgg_front #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_front (
        .angle_ch  (angle_ch),
        .ctrl      (ctrl),
        .colors    (colors),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    pgg_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_item  (pop_item)
    );

    pgg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_item (pop_item),
        .pop      (pop),
        .color_ch (color_ch)
    );

endmodule

// ===== sv/pgg_checker.sv =====
// Port-level checker for the palette gradient generator, bound to the top level.
`include "palette_gradient_generator_assert.svh"

module pgg_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [pgg_pkg::CHAN_W-1:0]  red,
    input  logic [pgg_pkg::CHAN_W-1:0]  green,
    input  logic [pgg_pkg::CHAN_W-1:0]  blue,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgg_pkg::APB_AW-1:0]  paddr,
    input  logic [pgg_pkg::APB_DW-1:0]  pwdata,
    input  logic [pgg_pkg::APB_DW-1:0]  prdata
);
    import pgg_pkg::*;

    logic wr_smooth;
    logic rd_smooth;

    assign wr_smooth = psel && penable && pwrite && paddr[APB_AW-1:2] == REG_SMOOTH_MODE;
    assign rd_smooth = psel && !pwrite && paddr[APB_AW-1:2] == REG_SMOOTH_MODE;

    `PGG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(red) && $stable(green) && $stable(blue))
    // a full queue only happens behind a stalled result
    `PGG_ASSERT_IMPL(a_full_means_stall, !in_ready, out_valid)
    `PGG_ASSERT_NEXT(a_smooth_readback, wr_smooth, rd_smooth |-> prdata[0] == $past(pwdata[0]))

endmodule

bind palette_gradient_generator pgg_checker u_pgg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (angle_ch.ready),
    .out_valid (color_ch.valid),
    .out_ready (color_ch.ready),
    .red       (color_ch.red),
    .green     (color_ch.green),
    .blue      (color_ch.blue),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

// ===== sim/tb_palette_gradient_generator.sv =====
// Self-checking testbench for the palette gradient generator: directed and random angle traffic.
`timescale 1ns / 1ps

module tb_palette_gradient_generator;
    import pgg_pkg::*;

    localparam int PALETTE_SIZE   = PALETTE_SIZE_DEF;
    localparam int RANDOM_PHASES  = 17;
    localparam int PHASE_ITEMS    = 100;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    pgg_angle_if angle_bus ();
    pgg_color_if color_bus ();

    // register shadow
    logic [NUM_COLORS-1:0] mask_cfg;
    logic                  smooth_cfg;
    color_t                palette_cfg [NUM_COLORS];

    color_t                pending_colors [$];
    int                    err_count;
    int                    idle_cycles;
    int                    burst_left;
    bit                    steady_source;
    sink_mode_e            sink_mode;
    int unsigned           stall_tick;

    palette_gradient_generator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle_ch (angle_bus),
        .color_ch (color_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] from_c,
                                                     input logic [CHAN_W-1:0] to_c,
                                                     input logic [ANGLE_W-1:0] frac);
        int span;
        int scaled;
        span   = int'(to_c) - int'(from_c);
        scaled = span * int'(frac);
        // arithmetic shift floors toward minus infinity
        return CHAN_W'(int'(from_c) + (scaled >>> ANGLE_W));
    endfunction

    function automatic color_t gradient_color(input logic [ANGLE_W-1:0] phase,
                                              input logic [ANGLE_W-1:0] offset);
        color_t             stops [NUM_COLORS];
        int unsigned        n_stops;
        logic [ANGLE_W-1:0] angle;
        int unsigned        prod;
        int unsigned        seg;
        int unsigned        nxt;
        logic [ANGLE_W-1:0] frac;
        color_t             ca;
        color_t             cb;
        color_t             mixed;
        n_stops = 0;
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            if (mask_cfg[i])
            begin
                stops[n_stops] = palette_cfg[i];
                n_stops++;
            end
        end
        if (n_stops == 0)
            return WHITE;
        if (n_stops == 1)
            return stops[0];
        angle = phase + offset;
        prod  = int'(angle) * n_stops;
        seg   = prod >> ANGLE_W;
        frac  = prod[ANGLE_W-1:0];
        if (seg >= n_stops)
            seg = n_stops - 1;
        ca = stops[seg];
        if (!smooth_cfg)
            return ca;
        nxt = (seg + 1 >= n_stops) ? 0 : seg + 1;
        cb  = stops[nxt];
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            mixed[c*CHAN_W +: CHAN_W] = blend_chan(ca[c*CHAN_W +: CHAN_W],
                                                   cb[c*CHAN_W +: CHAN_W], frac);
        end
        return mixed;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_ENABLE_MASK)
            mask_cfg = value[NUM_COLORS-1:0];
        else if (idx == REG_SMOOTH_MODE)
            smooth_cfg = value[0];
        else
            palette_cfg[idx - REG_COLOR_0] = value[COLOR_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all_regs();
        logic [APB_DW-1:0] want;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (REG_IDX_W'(i) == REG_ENABLE_MASK)
                want = APB_DW'(mask_cfg);
            else if (REG_IDX_W'(i) == REG_SMOOTH_MODE)
                want = APB_DW'(smooth_cfg);
            else
                want = APB_DW'(palette_cfg[i - REG_COLOR_0]);
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {REG_IDX_W'(i), 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata !== want)
            begin
                $error("register %0d: expected %0h, got %0h", i, want, prdata);
                err_count++;
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic send_angle(input logic [ANGLE_W-1:0] phase, input logic [ANGLE_W-1:0] offset);
        int gap;
        if (!steady_source && burst_left <= 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            @(negedge clk);
            angle_bus.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        angle_bus.valid        <= 1'b1;
        angle_bus.phase_angle  <= phase;
        angle_bus.offset_angle <= offset;
        @(posedge clk);
        while (!angle_bus.ready)
            @(posedge clk);
        pending_colors.push_back(gradient_color(phase, offset));
        burst_left--;
    endtask

    // stop sending and let every outstanding color come back
    task automatic settle();
        @(negedge clk);
        angle_bus.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic test_register_access();
        sink_mode     = SINK_OPEN;
        steady_source = 1'b1;
        read_all_regs();
        send_angle(16'h0000, 16'h0000);
        send_angle(16'hFFFF, 16'hFFFF);
        settle();
    endtask

    task automatic test_single_color();
        sink_mode     = SINK_RANDOM;
        steady_source = 1'b0;
        write_reg(REG_IDX_W'(REG_COLOR_0 + 5), 32'h00A5C3E1);
        write_reg(REG_ENABLE_MASK, 32'h20);
        send_angle(16'h1234, 16'h5678);
        send_angle(16'hFFFF, 16'h0001);
        settle();
        write_reg(REG_SMOOTH_MODE, 32'h0);
        send_angle(16'h8000, 16'h3FFF);
        settle();
    endtask

    task automatic test_two_stop_blend();
        sink_mode     = SINK_PERIODIC;
        steady_source = 1'b1;
        write_reg(REG_IDX_W'(REG_COLOR_0), 32'h000000);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 3), 32'hFFFFFF);
        write_reg(REG_ENABLE_MASK, 32'h09);
        write_reg(REG_SMOOTH_MODE, 32'h1);
        send_angle(16'h0000, 16'h0000);
        send_angle(16'h4000, 16'h0000);
        send_angle(16'h7FFF, 16'h0000);
        send_angle(16'h8000, 16'h0000);
        send_angle(16'h4000, 16'h8000);
        send_angle(16'hFFFF, 16'h0000);
        send_angle(16'hFFFF, 16'h0001);
        settle();
        write_reg(REG_SMOOTH_MODE, 32'h0);
        send_angle(16'h7FFF, 16'h0000);
        send_angle(16'h0000, 16'h8000);
        settle();
    endtask

    task automatic test_full_palette();
        sink_mode     = SINK_SPARSE;
        steady_source = 1'b0;
        write_reg(REG_IDX_W'(REG_COLOR_0), 32'hFF0000);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 1), 32'hFFFF00);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 2), 32'h00FF80);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 3), 32'h0000FF);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 4), 32'h8000FF);
        write_reg(REG_IDX_W'(REG_COLOR_0 + 5), 32'h102030);
        write_reg(REG_ENABLE_MASK, 32'h3F);
        write_reg(REG_SMOOTH_MODE, 32'h1);
        send_angle(16'h2AAA, 16'h0000);
        send_angle(16'h2AAB, 16'h0000);
        send_angle(16'hAAAA, 16'h0000);
        send_angle(16'hFFFF, 16'h0000);
        settle();
        write_reg(REG_SMOOTH_MODE, 32'h0);
        send_angle(16'hD555, 16'h0000);
        send_angle(16'hFFFF, 16'h0000);
        settle();
        read_all_regs();
    endtask

    function automatic color_t pick_color();
        color_t c;
        case ($urandom_range(0, 3))
            0: c = '0;
            1: c = '1;
            2:
            begin
                for (int k = 0; k < NUM_CHAN; k++)
                begin
                    case ($urandom_range(0, 2))
                        0: c[k*CHAN_W +: CHAN_W] = '0;
                        1: c[k*CHAN_W +: CHAN_W] = '1;
                        default: c[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
                    endcase
                end
            end
            default: c = COLOR_W'($urandom);
        endcase
        return c;
    endfunction

    task automatic test_random_traffic();
        logic [NUM_COLORS-1:0] mask;
        logic [ANGLE_W-1:0]    phase;
        logic [ANGLE_W-1:0]    offset;
        int                    n;
        int                    s;
        int                    target;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0: mask = '0;
                1: mask = NUM_COLORS'(1) << $urandom_range(0, NUM_COLORS - 1);
                2: mask = '1;
                default: mask = NUM_COLORS'($urandom);
            endcase
            for (int i = 0; i < NUM_COLORS; i++)
                write_reg(REG_IDX_W'(REG_COLOR_0 + i), {8'($urandom), pick_color()});
            write_reg(REG_ENABLE_MASK, {26'($urandom), mask});
            write_reg(REG_SMOOTH_MODE, {31'($urandom), 1'($urandom)});
            read_all_regs();
            sink_mode     = sink_mode_e'($urandom_range(0, 3));
            steady_source = ($urandom_range(0, 3) == 0);
            n = $countones(mask_cfg);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                offset = ANGLE_W'($urandom);
                phase  = ANGLE_W'($urandom);
                // aim some angles at segment boundaries
                if (n >= 2 && $urandom_range(0, 3) == 0)
                begin
                    s      = $urandom_range(0, n - 1);
                    target = (s * 65536 + n - 1) / n + int'($urandom_range(0, 4)) - 2;
                    phase  = ANGLE_W'(target) - offset;
                end
                send_angle(phase, offset);
            end
            settle();
        end
    endtask

    always @(negedge clk)
    begin
        stall_tick++;
        case (sink_mode)
            SINK_OPEN:     color_bus.ready <= 1'b1;
            SINK_RANDOM:   color_bus.ready <= ($urandom_range(0, 3) != 0);
            SINK_PERIODIC: color_bus.ready <= ((stall_tick % 7) < 4);
            default:       color_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_colors
        color_t want;
        if (rst_n && color_bus.valid && color_bus.ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("color transfer with no item outstanding");
                err_count++;
            end
            else
            begin
                want = pending_colors.pop_front();
                if (color_bus.red !== want[23:16])
                begin
                    $error("red: expected %0h, got %0h", want[23:16], color_bus.red);
                    err_count++;
                end
                if (color_bus.green !== want[15:8])
                begin
                    $error("green: expected %0h, got %0h", want[15:8], color_bus.green);
                    err_count++;
                end
                if (color_bus.blue !== want[7:0])
                begin
                    $error("blue: expected %0h, got %0h", want[7:0], color_bus.blue);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (angle_bus.valid && angle_bus.ready)
            || (color_bus.valid && color_bus.ready)
            || (!angle_bus.valid && pending_colors.size() == 0))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_palette_gradient_generator: errors");
                $finish;
            end
        end
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        angle_bus.valid        = 1'b0;
        angle_bus.phase_angle  = '0;
        angle_bus.offset_angle = '0;
        color_bus.ready        = 1'b0;
        mask_cfg               = '0;
        smooth_cfg             = 1'b1;
        palette_cfg            = COLOR_RESET;
        err_count              = 0;
        idle_cycles            = 0;
        burst_left             = 0;
        steady_source          = 1'b1;
        sink_mode              = SINK_OPEN;
        stall_tick             = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_single_color();
        test_two_stop_blend();
        test_full_palette();
        test_random_traffic();
        settle();

        if (err_count == 0 && pending_colors.size() == 0)
            $display("tb_palette_gradient_generator: clean");
        else
            $display("tb_palette_gradient_generator: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pgg_pkg.sv
sv/pgg_if.sv
sv/pgg_regs.sv
sv/pgg_front.sv
sv/pgg_fifo.sv
sv/pgg_back.sv
sv/palette_gradient_generator.sv
sv/pgg_checker.sv
sim/tb_palette_gradient_generator.sv
